// ===== sv/lfsq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED fade step queue package
// Command codes, job encoding and step entry layout shared by the front end,
// the job queue and the back end of the fade step queue.
// ----------------------------------------------------------------------------
package lfsq_pkg;

   // Default depth of the step queue.
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // Level space. Level indices travel in fixed 6-bit fields.
   localparam int LEVEL_COUNT = 64;
   localparam int LEVEL_WIDTH = 6;
   localparam int HOLD_WIDTH  = 8;
   localparam int MODE_WIDTH  = 3;

   localparam logic [LEVEL_WIDTH-1:0] TOP_LEVEL = LEVEL_WIDTH'(LEVEL_COUNT - 1);

   // Every step of a range run is held for one tick.
   localparam logic [HOLD_WIDTH-1:0] RANGE_HOLD = HOLD_WIDTH'(1);

   // Command codes on the request mode field.
   localparam logic [MODE_WIDTH-1:0] MODE_TICK  = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SET   = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_INC   = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_DEC   = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_RANGE = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_CLEAR = 3'd5;

   // Depth of the job queue between front and back end.
   localparam int JOB_FIFO_DEPTH = 2;

   typedef enum logic [2:0] {
      JOB_NOP,
      JOB_TICK,
      JOB_SET,
      JOB_INC,
      JOB_DEC,
      JOB_RANGE,
      JOB_CLEAR
   } job_op_type;

   // A classified command. For a range, level is the clamped end and start
   // the clamped start.
   typedef struct packed {
      job_op_type             op;
      logic [LEVEL_WIDTH-1:0] level;
      logic [LEVEL_WIDTH-1:0] start;
      logic [HOLD_WIDTH-1:0]  hold;
   } job_type;

   // One entry of the step store.
   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic [HOLD_WIDTH-1:0]  hold;
   } step_type;

endpackage
`default_nettype wire

// ===== sv/lfsq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED fade step queue front end
// Takes command beats, tracks the busy flag and turns each command into a job.
// ----------------------------------------------------------------------------
module lfsq_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [lfsq_pkg::MODE_WIDTH-1:0]    req_mode,
   input  wire logic [lfsq_pkg::LEVEL_WIDTH-1:0]   req_target_index,
   input  wire logic [lfsq_pkg::LEVEL_WIDTH-1:0]   req_range_start,
   input  wire logic [lfsq_pkg::HOLD_WIDTH-1:0]    req_hold_ticks,
   input  wire logic                               done,
   output logic                                    job_push,
   output lfsq_pkg::job_type                       job
);

   logic busy_ff;
   logic busy_in;
   logic [lfsq_pkg::LEVEL_WIDTH-1:0] clamp_start;
   logic [lfsq_pkg::LEVEL_WIDTH-1:0] clamp_end;

   assign job_push = start && !busy_ff;
   assign busy     = busy_ff;

   // Range ends above the top level are pulled down to it.
   assign clamp_start = (req_range_start > lfsq_pkg::TOP_LEVEL) ?
                        lfsq_pkg::TOP_LEVEL : req_range_start;
   assign clamp_end   = (req_target_index > lfsq_pkg::TOP_LEVEL) ?
                        lfsq_pkg::TOP_LEVEL : req_target_index;

   always_comb begin
      job.op    = lfsq_pkg::JOB_NOP;
      job.level = req_target_index;
      job.start = clamp_start;
      job.hold  = req_hold_ticks;
      case (req_mode)
         lfsq_pkg::MODE_TICK: begin
            job.op = lfsq_pkg::JOB_TICK;
         end
         lfsq_pkg::MODE_SET: begin
            // A level outside the table is ignored.
            job.op = (req_target_index > lfsq_pkg::TOP_LEVEL) ?
                     lfsq_pkg::JOB_NOP : lfsq_pkg::JOB_SET;
         end
         lfsq_pkg::MODE_INC: begin
            job.op = lfsq_pkg::JOB_INC;
         end
         lfsq_pkg::MODE_DEC: begin
            job.op = lfsq_pkg::JOB_DEC;
         end
         lfsq_pkg::MODE_RANGE: begin
            job.op    = lfsq_pkg::JOB_RANGE;
            job.level = clamp_end;
            job.hold  = lfsq_pkg::RANGE_HOLD;
         end
         lfsq_pkg::MODE_CLEAR: begin
            job.op = lfsq_pkg::JOB_CLEAR;
         end
         default: begin
            job.op = lfsq_pkg::JOB_NOP;
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      if (job_push) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/lfsq_job_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED fade step queue job FIFO
// Short queue of classified jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module lfsq_job_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lfsq_pkg::job_type push_job,
   input  wire logic              pop,
   output logic                   job_valid,
   output lfsq_pkg::job_type      head_job
);

   localparam int PtrWidth   = $clog2(lfsq_pkg::JOB_FIFO_DEPTH);
   localparam int CountWidth = $clog2(lfsq_pkg::JOB_FIFO_DEPTH + 1);

   lfsq_pkg::job_type entry_ff [lfsq_pkg::JOB_FIFO_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign job_valid = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];
   assign do_push   = push && (count_ff != CountWidth'(lfsq_pkg::JOB_FIFO_DEPTH));
   assign do_pop    = pop && job_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(lfsq_pkg::JOB_FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(lfsq_pkg::JOB_FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/lfsq_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED fade step queue back end
// Holds the step store and the shown level, carries out one job at a time
// and presents the result beat.
// ----------------------------------------------------------------------------
module lfsq_back #(
   parameter int QUEUE_DEPTH = lfsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     job_valid,
   input  wire lfsq_pkg::job_type                        head_job,
   output logic                                          job_pop,
   output logic                                          done,
   output logic                                          rsp_valid,
   output logic [lfsq_pkg::LEVEL_WIDTH-1:0]              rsp_current_index,
   output logic                                          rsp_level_changed,
   output logic [lfsq_pkg::HOLD_WIDTH-1:0]               rsp_hold_left,
   output logic                                          rsp_max_reached,
   output logic                                          rsp_rising,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]              rsp_queue_count
);

   localparam int PtrWidth   = $clog2(QUEUE_DEPTH);
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_RANGE,
      ST_RESULT
   } state_type;

   state_type                          state_ff, state_in;
   lfsq_pkg::job_type                  job_ff, job_in;
   logic [PtrWidth-1:0]                head_ff, head_in;
   logic [PtrWidth-1:0]                tail_ff, tail_in;
   logic [CountWidth-1:0]              fill_ff, fill_in;
   logic [lfsq_pkg::LEVEL_WIDTH-1:0]   shown_ff, shown_in;
   logic [lfsq_pkg::HOLD_WIDTH-1:0]    hold_ff, hold_in;
   logic                               top_ff, top_in;
   logic                               dir_ff, dir_in;
   logic                               changed_ff, changed_in;
   logic [lfsq_pkg::LEVEL_WIDTH-1:0]   cur_ff, cur_in;

   lfsq_pkg::step_type                 store [QUEUE_DEPTH];
   lfsq_pkg::step_type                 rd_step_ff;

   logic                               push_req;
   lfsq_pkg::step_type                 push_step;
   logic                               store_wr;
   logic [lfsq_pkg::LEVEL_WIDTH-1:0]   step_level;
   logic [lfsq_pkg::LEVEL_WIDTH-1:0]   range_next;

   // Level the increment or decrement aims at, saturating at either end.
   always_comb begin
      step_level = shown_ff;
      if (job_ff.op == lfsq_pkg::JOB_INC) begin
         if (shown_ff < lfsq_pkg::TOP_LEVEL) begin
            step_level = shown_ff + lfsq_pkg::LEVEL_WIDTH'(1);
         end
      end else if (shown_ff != '0) begin
         step_level = shown_ff - lfsq_pkg::LEVEL_WIDTH'(1);
      end
   end

   assign range_next = (cur_ff < job_ff.level) ? cur_ff + lfsq_pkg::LEVEL_WIDTH'(1) :
                                                 cur_ff - lfsq_pkg::LEVEL_WIDTH'(1);

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      shown_in   = shown_ff;
      hold_in    = hold_ff;
      top_in     = top_ff;
      dir_in     = dir_ff;
      changed_in = changed_ff;
      cur_in     = cur_ff;
      job_pop    = 1'b0;
      push_req   = 1'b0;
      push_step  = '{level: job_ff.level, hold: job_ff.hold};
      store_wr   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop    = 1'b1;
               job_in     = head_job;
               changed_in = 1'b0;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESULT;
            case (job_ff.op)
               lfsq_pkg::JOB_TICK: begin
                  if (hold_ff == '0) begin
                     if (fill_ff != '0) begin
                        // The head entry is read this cycle and loaded next.
                        head_in  = (head_ff == PtrWidth'(QUEUE_DEPTH - 1)) ?
                                   '0 : head_ff + PtrWidth'(1);
                        fill_in  = fill_ff - CountWidth'(1);
                        state_in = ST_POP;
                     end
                  end else begin
                     hold_in = hold_ff - lfsq_pkg::HOLD_WIDTH'(1);
                  end
               end
               lfsq_pkg::JOB_SET: begin
                  push_req = 1'b1;
               end
               lfsq_pkg::JOB_INC,
               lfsq_pkg::JOB_DEC: begin
                  push_req        = (step_level != shown_ff);
                  push_step.level = step_level;
                  top_in          = (step_level == lfsq_pkg::TOP_LEVEL);
                  dir_in          = (job_ff.op == lfsq_pkg::JOB_INC);
               end
               lfsq_pkg::JOB_RANGE: begin
                  if (job_ff.start == job_ff.level) begin
                     push_req = 1'b1;
                  end else begin
                     cur_in   = job_ff.start;
                     state_in = ST_RANGE;
                  end
               end
               lfsq_pkg::JOB_CLEAR: begin
                  head_in = '0;
                  tail_in = '0;
                  fill_in = '0;
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_POP: begin
            shown_in   = rd_step_ff.level;
            hold_in    = rd_step_ff.hold - lfsq_pkg::HOLD_WIDTH'(1);
            changed_in = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RANGE: begin
            // One step of the run is queued per cycle.
            push_req        = 1'b1;
            push_step.level = range_next;
            cur_in          = range_next;
            if (range_next == job_ff.level) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A push to a full store is dropped.
      if (push_req && (fill_ff != CountWidth'(QUEUE_DEPTH))) begin
         store_wr = 1'b1;
         tail_in  = (tail_ff == PtrWidth'(QUEUE_DEPTH - 1)) ?
                    '0 : tail_ff + PtrWidth'(1);
         fill_in  = fill_ff + CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store[tail_ff] <= push_step;
      end
      rd_step_ff <= store[head_ff];
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      cur_ff <= cur_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         fill_ff    <= '0;
         shown_ff   <= '0;
         hold_ff    <= '0;
         top_ff     <= 1'b0;
         dir_ff     <= 1'b0;
         changed_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         fill_ff    <= fill_in;
         shown_ff   <= shown_in;
         hold_ff    <= hold_in;
         top_ff     <= top_in;
         dir_ff     <= dir_in;
         changed_ff <= changed_in;
      end
   end

   assign done              = (state_ff == ST_RESULT);
   assign rsp_valid         = (state_ff == ST_RESULT);
   assign rsp_current_index = shown_ff;
   assign rsp_level_changed = changed_ff;
   assign rsp_hold_left     = hold_ff;
   assign rsp_max_reached   = top_ff;
   assign rsp_rising        = dir_ff;
   assign rsp_queue_count   = fill_ff;

   // The fill count never passes the store depth.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CountWidth'(QUEUE_DEPTH))
      else $error("step store fill count above depth");

   // A pop always reports a level change in the result that follows it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |=> (state_ff == ST_RESULT) && changed_ff)
      else $error("pop not reported as a level change");

   // A range run never steps while already sitting on its end.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RANGE) |-> (cur_ff != job_ff.level))
      else $error("range run passed its end");

   // Head and tail meet only when the store is empty or full.
   assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) |-> (fill_ff == '0) || (fill_ff == CountWidth'(QUEUE_DEPTH)))
      else $error("step store pointers out of step with fill count");

endmodule
`default_nettype wire

// ===== sv/led_fade_step_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED fade step queue unit
// Command-driven queue of LED brightness steps with tick-driven playback.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low, and the block
// then works on it alone: busy stays high until its single result beat has
// been shown on the rsp_ ports for one cycle with rsp_valid high. There is no
// way to hold results off, so the receiver must take every rsp_valid cycle.
// A tick, set, increment, decrement, clear or single-step range goes from
// acceptance through the job queue and the idle, execute and result states
// of the back end to the result beat (a tick that pops a step also passes
// the pop state, because the step store read is registered); the next
// command can be accepted on the cycle after the result beat. A range from
// start to end pushes one step per cycle in the range state, through the
// step store write port. Steps pushed into a full queue are dropped.
//
// Inside, a front end classifies each command into a job and places it in a
// two-entry job queue; the back end pulls jobs from that queue, owns the step
// store, the shown level and the hold counter, and drives the result ports
// from its registers. The step store has no reset: only entries that were
// written are ever read.
// ----------------------------------------------------------------------------
module led_fade_step_queue_unit #(
   parameter int QUEUE_DEPTH = lfsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic [lfsq_pkg::MODE_WIDTH-1:0]        req_mode,
   input  wire logic [lfsq_pkg::LEVEL_WIDTH-1:0]       req_target_index,
   input  wire logic [lfsq_pkg::LEVEL_WIDTH-1:0]       req_range_start,
   input  wire logic [lfsq_pkg::HOLD_WIDTH-1:0]        req_hold_ticks,
   output logic                                        rsp_valid,
   output logic [lfsq_pkg::LEVEL_WIDTH-1:0]            rsp_current_index,
   output logic                                        rsp_level_changed,
   output logic [lfsq_pkg::HOLD_WIDTH-1:0]             rsp_hold_left,
   output logic                                        rsp_max_reached,
   output logic                                        rsp_rising,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]            rsp_queue_count
);

   // Job handoff between the front end and the job queue.
   logic              job_push;
   lfsq_pkg::job_type new_job;

   // Job handoff between the job queue and the back end.
   logic              job_valid;
   logic              job_pop;
   lfsq_pkg::job_type head_job;

   // The back end signals the result beat so the front end can drop busy.
   logic              done;

   lfsq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_target_index (req_target_index),
      .req_range_start  (req_range_start),
      .req_hold_ticks   (req_hold_ticks),
      .done             (done),
      .job_push         (job_push),
      .job              (new_job)
   );

   lfsq_job_fifo u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (new_job),
      .pop       (job_pop),
      .job_valid (job_valid),
      .head_job  (head_job)
   );

   lfsq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (job_valid),
      .head_job          (head_job),
      .job_pop           (job_pop),
      .done              (done),
      .rsp_valid         (rsp_valid),
      .rsp_current_index (rsp_current_index),
      .rsp_level_changed (rsp_level_changed),
      .rsp_hold_left     (rsp_hold_left),
      .rsp_max_reached   (rsp_max_reached),
      .rsp_rising        (rsp_rising),
      .rsp_queue_count   (rsp_queue_count)
   );

endmodule
`default_nettype wire

// ===== tb/sv/fade_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade step queue checker
// Watches the command and result beats of the fade step queue, keeps its own
// copy of the queue, shown level, hold counter and flags, and compares every
// result beat field by field with the prediction for the oldest open command.
// ----------------------------------------------------------------------------
module fade_queue_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic                             busy,
   input  wire logic [lfsq_pkg::MODE_WIDTH-1:0]  req_mode,
   input  wire logic [lfsq_pkg::LEVEL_WIDTH-1:0] req_target_index,
   input  wire logic [lfsq_pkg::LEVEL_WIDTH-1:0] req_range_start,
   input  wire logic [lfsq_pkg::HOLD_WIDTH-1:0]  req_hold_ticks,
   input  wire logic                             rsp_valid,
   input  wire logic [lfsq_pkg::LEVEL_WIDTH-1:0] rsp_current_index,
   input  wire logic                             rsp_level_changed,
   input  wire logic [lfsq_pkg::HOLD_WIDTH-1:0]  rsp_hold_left,
   input  wire logic                             rsp_max_reached,
   input  wire logic                             rsp_rising,
   input  wire logic [$clog2(lfsq_pkg::QUEUE_DEPTH_DEFAULT+1)-1:0] rsp_queue_count,
   output int                                    fail_count,
   output int                                    pending_count
);
   import lfsq_pkg::*;

   localparam int DEPTH       = QUEUE_DEPTH_DEFAULT;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic                   changed;
      logic [HOLD_WIDTH-1:0]  hold_left;
      logic                   top;
      logic                   rising;
      logic [COUNT_WIDTH-1:0] fill;
   } fade_status_type;

   logic [LEVEL_WIDTH-1:0] step_level_mem [DEPTH];
   logic [HOLD_WIDTH-1:0]  step_hold_mem  [DEPTH];
   int                     head_idx;
   int                     tail_idx;
   int                     fill_level;
   logic [LEVEL_WIDTH-1:0] shown_level;
   logic [HOLD_WIDTH-1:0]  hold_timer;
   logic                   top_seen;
   logic                   going_up;
   fade_status_type        status_due_q [$];

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0d, %0d due", name, got, want));
      end
   endtask

   // A push into a full queue is dropped without a trace.
   task automatic queue_step(input logic [LEVEL_WIDTH-1:0] level,
                             input logic [HOLD_WIDTH-1:0] hold);
      if (fill_level < DEPTH) begin
         step_level_mem[tail_idx] = level;
         step_hold_mem[tail_idx]  = hold;
         tail_idx                 = (tail_idx + 1) % DEPTH;
         fill_level++;
      end
   endtask

   task automatic play_command(input logic [MODE_WIDTH-1:0] mode,
                               input logic [LEVEL_WIDTH-1:0] target,
                               input logic [LEVEL_WIDTH-1:0] first,
                               input logic [HOLD_WIDTH-1:0] hold,
                               output fade_status_type status);
      logic [LEVEL_WIDTH-1:0] next_level;
      logic [LEVEL_WIDTH-1:0] walk;
      logic                   popped;
      popped = 1'b0;
      case (mode)
         MODE_TICK: begin
            if (hold_timer != '0) begin
               hold_timer--;
            end else if (fill_level != 0) begin
               shown_level = step_level_mem[head_idx];
               hold_timer  = step_hold_mem[head_idx] - 1'b1;
               head_idx    = (head_idx + 1) % DEPTH;
               fill_level--;
               popped      = 1'b1;
            end
         end
         MODE_SET: begin
            // A 6-bit level never exceeds the top level, so it is never ignored.
            queue_step(target, hold);
         end
         MODE_INC: begin
            next_level = shown_level;
            if (next_level < TOP_LEVEL) begin
               next_level++;
               queue_step(next_level, hold);
            end
            top_seen = (next_level == TOP_LEVEL);
            going_up = 1'b1;
         end
         MODE_DEC: begin
            next_level = shown_level;
            if (next_level != '0) begin
               next_level--;
               queue_step(next_level, hold);
            end
            top_seen = (next_level == TOP_LEVEL);
            going_up = 1'b0;
         end
         MODE_RANGE: begin
            // Both ends fit the level space already, so clamping changes nothing.
            if (first == target) begin
               queue_step(first, RANGE_HOLD);
            end else begin
               walk = first;
               while (walk != target) begin
                  if (walk < target) begin
                     walk++;
                  end else begin
                     walk--;
                  end
                  queue_step(walk, RANGE_HOLD);
               end
            end
         end
         MODE_CLEAR: begin
            head_idx   = 0;
            tail_idx   = 0;
            fill_level = 0;
         end
         default: begin
         end
      endcase
      status.level     = shown_level;
      status.changed   = popped;
      status.hold_left = hold_timer;
      status.top       = top_seen;
      status.rising    = going_up;
      status.fill      = COUNT_WIDTH'(fill_level);
   endtask

   always @(posedge clock) begin : watch
      fade_status_type predicted;
      fade_status_type due;
      if (reset) begin
         head_idx    = 0;
         tail_idx    = 0;
         fill_level  = 0;
         shown_level = '0;
         hold_timer  = '0;
         top_seen    = 1'b0;
         going_up    = 1'b0;
         fail_count  = 0;
         status_due_q.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (status_due_q.size() == 0) begin
               report_mismatch("result beat with no command open");
            end else begin
               due = status_due_q.pop_front();
               check_field("current_index", 8'(rsp_current_index), 8'(due.level));
               check_field("level_changed", 8'(rsp_level_changed), 8'(due.changed));
               check_field("hold_left", rsp_hold_left, due.hold_left);
               check_field("max_reached", 8'(rsp_max_reached), 8'(due.top));
               check_field("rising", 8'(rsp_rising), 8'(due.rising));
               check_field("queue_count", 8'(rsp_queue_count), 8'(due.fill));
            end
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("rsp_valid is unknown");
         end
         if (start && busy === 1'b0) begin
            play_command(req_mode, req_target_index, req_range_start, req_hold_ticks,
                         predicted);
            status_due_q.push_back(predicted);
         end
      end
      pending_count = status_due_q.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade step queue unit testbench
// Drives directed and random fade commands into the step queue unit, with
// random idle cycles on the command side, and leaves prediction and checking
// to a checker that sits beside the unit; the verdict rests on its count.
// ----------------------------------------------------------------------------
module testbench;
   import lfsq_pkg::*;

   // The mode field has two codes that the unit must treat as no-ops.
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_HI = 3'd7;

   // Number of random commands (no-op modes not counted) before the run ends.
   localparam int COMMAND_GOAL = 1600;

   // This covers the last result beat even of a full-span range, with room
   // to spare.
   localparam int SETTLE_CYCLES = 80;

   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH_DEFAULT + 1);

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic [MODE_WIDTH-1:0]  req_mode = '0;
   logic [LEVEL_WIDTH-1:0] req_target_index = '0;
   logic [LEVEL_WIDTH-1:0] req_range_start = '0;
   logic [HOLD_WIDTH-1:0]  req_hold_ticks = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [LEVEL_WIDTH-1:0] rsp_current_index;
   logic                   rsp_level_changed;
   logic [HOLD_WIDTH-1:0]  rsp_hold_left;
   logic                   rsp_max_reached;
   logic                   rsp_rising;
   logic [COUNT_WIDTH-1:0] rsp_queue_count;
   int                     fail_count;
   int                     pending_count;

   // Random commands accepted so far, and whether the sender may idle.
   int                     commands_sent = 0;
   bit                     idle_enable = 1'b1;

   always #5 clock = ~clock;

   led_fade_step_queue_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_target_index  (req_target_index),
      .req_range_start   (req_range_start),
      .req_hold_ticks    (req_hold_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_current_index (rsp_current_index),
      .rsp_level_changed (rsp_level_changed),
      .rsp_hold_left     (rsp_hold_left),
      .rsp_max_reached   (rsp_max_reached),
      .rsp_rising        (rsp_rising),
      .rsp_queue_count   (rsp_queue_count)
   );

   fade_queue_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_target_index  (req_target_index),
      .req_range_start   (req_range_start),
      .req_hold_ticks    (req_hold_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_current_index (rsp_current_index),
      .rsp_level_changed (rsp_level_changed),
      .rsp_hold_left     (rsp_hold_left),
      .rsp_max_reached   (rsp_max_reached),
      .rsp_rising        (rsp_rising),
      .rsp_queue_count   (rsp_queue_count),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   // Sends one command beat. Inputs change only at the falling edge, and start
   // gets a single assignment per time step: it is lowered only when an idle
   // gap comes first. The gap has a random length, so it lands on the
   // busy phase of the previous command as well as on the idle phase after it.
   // The beat is taken at the first rising edge at which busy is low; busy is
   // sampled at that edge, before the unit updates it.
   task automatic send_command(input logic [MODE_WIDTH-1:0] mode,
                               input logic [LEVEL_WIDTH-1:0] target,
                               input logic [LEVEL_WIDTH-1:0] first,
                               input logic [HOLD_WIDTH-1:0] hold);
      int gap;
      gap = 0;
      if (idle_enable && $urandom_range(99) < 16) begin
         gap = $urandom_range(8, 1);
      end
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            <= 1'b1;
      req_mode         <= mode;
      req_target_index <= target;
      req_range_start  <= first;
      req_hold_ticks   <= hold;
      do @(posedge clock); while (busy !== 1'b0);
      if (mode <= MODE_CLEAR) begin
         commands_sent++;
      end
   endtask

   // Holds the sender off until the checker has seen every result beat it is
   // waiting for. The checker count is read at the falling edge, where it is
   // stable.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Most holds are short so that steps keep flowing; a few take the full
   // range, zero among them, which stands for a hold of 256 ticks.
   function automatic logic [HOLD_WIDTH-1:0] pick_hold();
      int roll;
      roll = $urandom_range(99);
      if (roll < 85) begin
         return HOLD_WIDTH'($urandom_range(3, 1));
      end else if (roll < 95) begin
         return HOLD_WIDTH'($urandom_range(15, 4));
      end
      return HOLD_WIDTH'($urandom_range(255));
   endfunction

   // A range usually spans a few levels around its start; now and then it
   // runs to an arbitrary end and may overflow the queue.
   task automatic send_range();
      int first;
      int last;
      first = $urandom_range(63);
      if ($urandom_range(9) == 0) begin
         last = $urandom_range(63);
      end else begin
         last = first + $urandom_range(10) - 5;
         if (last < 0) begin
            last = 0;
         end else if (last > 63) begin
            last = 63;
         end
      end
      send_command(MODE_RANGE, LEVEL_WIDTH'(last), LEVEL_WIDTH'(first),
                   HOLD_WIDTH'($urandom_range(255)));
   endtask

   // One command that adds to the queue, with an occasional clear mixed in.
   // Unused fields carry random values so that every bit moves.
   task automatic send_fill();
      int roll;
      roll = $urandom_range(19);
      if (roll < 8) begin
         send_command(MODE_SET, LEVEL_WIDTH'($urandom_range(63)),
                      LEVEL_WIDTH'($urandom_range(63)), pick_hold());
      end else if (roll < 12) begin
         send_command(MODE_INC, LEVEL_WIDTH'($urandom_range(63)),
                      LEVEL_WIDTH'($urandom_range(63)), pick_hold());
      end else if (roll < 16) begin
         send_command(MODE_DEC, LEVEL_WIDTH'($urandom_range(63)),
                      LEVEL_WIDTH'($urandom_range(63)), pick_hold());
      end else if (roll < 19) begin
         send_range();
      end else begin
         send_command(MODE_CLEAR, LEVEL_WIDTH'($urandom_range(63)),
                      LEVEL_WIDTH'($urandom_range(63)), HOLD_WIDTH'($urandom_range(255)));
      end
   endtask

   task automatic send_tick();
      send_command(MODE_TICK, LEVEL_WIDTH'($urandom_range(63)),
                   LEVEL_WIDTH'($urandom_range(63)), HOLD_WIDTH'($urandom_range(255)));
   endtask

   initial begin
      int roll;
      int count;

      // Reset is held from time zero and released at a falling edge.
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed part. A tick on an empty queue with the hold counter at zero
      // does nothing, and neither do the two unused modes.
      send_command(MODE_TICK, '0, '0, '0);
      send_command(MODE_SPARE_LO, '0, '0, '0);
      send_command(MODE_SPARE_HI, '1, '1, '1);
      // Decrement at level zero queues nothing but still sets the flags.
      send_command(MODE_DEC, '0, '0, 8'd5);
      // Set the top level, play it, then try to step above it: the increment
      // queues nothing but raises the max flag and the direction flag.
      send_command(MODE_SET, TOP_LEVEL, '0, 8'd2);
      send_command(MODE_TICK, '0, '0, '0);
      send_command(MODE_INC, '0, '0, 8'd3);
      send_command(MODE_TICK, '0, '0, '0);
      // A range whose ends are equal queues its start once.
      send_command(MODE_RANGE, 6'd10, 6'd10, '0);
      // A full upward sweep fills the queue; the rest of the run is dropped,
      // and so is a set that arrives while the queue is full.
      send_command(MODE_RANGE, TOP_LEVEL, '0, '1);
      send_command(MODE_SET, 6'd5, '0, 8'd1);
      send_command(MODE_CLEAR, '0, '0, '0);
      // A downward sweep from the top, then play its first step.
      send_command(MODE_RANGE, '0, TOP_LEVEL, '0);
      send_command(MODE_TICK, '0, '0, '0);
      send_command(MODE_CLEAR, '1, '1, '1);
      // A hold of zero wraps: the counter starts at 255 after the pop.
      send_command(MODE_SET, '0, '0, 8'd0);
      send_command(MODE_TICK, '0, '0, '0);
      send_command(MODE_DEC, '0, '0, 8'd9);
      send_command(MODE_TICK, '1, '1, '1);
      send_command(MODE_INC, '0, '0, 8'd255);
      send_command(MODE_CLEAR, '0, '0, '0);
      drain_results();

      // Random part. Most rounds queue a few steps and then tick through
      // them, so that pops, hold countdowns and full-queue drops keep
      // happening; some rounds are a longer range followed by ticks, and the
      // rest are single commands of any mode with random fields.
      commands_sent = 0;
      while (commands_sent < COMMAND_GOAL) begin
         // A long stretch in the middle runs with no random idle gaps.
         idle_enable = !(commands_sent >= 500 && commands_sent < 800);
         roll = $urandom_range(99);
         if (roll < 65) begin
            count = $urandom_range(6, 1);
            repeat (count) send_fill();
            count = $urandom_range(24, 1);
            repeat (count) send_tick();
         end else if (roll < 80) begin
            send_range();
            count = $urandom_range(20, 1);
            repeat (count) send_tick();
         end else begin
            send_command(MODE_WIDTH'($urandom_range(7)), LEVEL_WIDTH'($urandom_range(63)),
                         LEVEL_WIDTH'($urandom_range(63)), HOLD_WIDTH'($urandom_range(255)));
         end
         // Now and then the sender waits until every result beat is back.
         if ($urandom_range(49) == 0) begin
            drain_results();
         end
      end

      // Wait for the last result beats, then give the unit time to show any
      // stray beat before the verdict.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("led_fade_step_queue_unit test passed");
      end else begin
         $display("led_fade_step_queue_unit test failed");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this time.
   initial begin
      #10_000_000;
      $display("led_fade_step_queue_unit test failed");
      $finish;
   end

endmodule
